// ===== rtl/core/csk_pkg.sv =====
// types, constants and implicit weight function for the collation sort key builder
package csk_pkg;

  localparam int unsigned StoreDepthDef = 16;
  localparam int unsigned WeightW       = 16;
  localparam int unsigned CodePointW    = 21;

  localparam logic [WeightW-1:0] AaaaTangut = 16'hFB00;
  localparam logic [WeightW-1:0] AaaaNushu  = 16'hFB01;
  localparam logic [WeightW-1:0] AaaaKhitan = 16'hFB02;
  localparam logic [WeightW-1:0] BaseCore   = 16'hFB40;
  localparam logic [WeightW-1:0] BaseExt    = 16'hFB80;
  localparam logic [WeightW-1:0] BaseOther  = 16'hFBC0;
  localparam logic [WeightW-1:0] LowMask    = 16'h7FFF;
  localparam logic [WeightW-1:0] HighBit    = 16'h8000;
  localparam logic [WeightW-1:0] SecImplicit = 16'h0020;
  localparam logic [WeightW-1:0] TerImplicit = 16'h0002;

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_IMPLICIT = 2'd1,
    CMD_FINISH   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PASS_PRI = 2'd0,
    PASS_SEC = 2'd1,
    PASS_TER = 2'd2
  } pass_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IMPL2,
    ST_READ,
    ST_EMIT,
    ST_SEP
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [WeightW-1:0] primary_weight;
    logic [WeightW-1:0] secondary_weight;
    logic [WeightW-1:0] tertiary_weight;
    logic [CodePointW-1:0] code_point;
  } in_item_t;

  typedef struct packed {
    logic [WeightW-1:0] key_word;
    logic               last_word;
    logic               dropped;
  } out_item_t;

  typedef struct packed {
    logic [WeightW-1:0] p;
    logic [WeightW-1:0] s;
    logic [WeightW-1:0] t;
  } ce_t;

  localparam int unsigned CeW = $bits(ce_t);

  function automatic logic in_rng(logic [CodePointW-1:0] cp, logic [CodePointW-1:0] lo,
                                  logic [CodePointW-1:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  // returns {aaaa, bbbb}
  function automatic logic [2*WeightW-1:0] implicit_weights(logic [CodePointW-1:0] cp);
    logic [WeightW-1:0]    aaaa;
    logic [WeightW-1:0]    bbbb;
    logic [WeightW-1:0]    base;
    logic [CodePointW-1:0] off;
    if (in_rng(cp, 21'h17000, 21'h18AFF) || in_rng(cp, 21'h18D00, 21'h18D7F)) begin
      off  = cp - 21'h17000;
      aaaa = AaaaTangut;
      bbbb = (off[WeightW-1:0] & LowMask) | HighBit;
    end else if (in_rng(cp, 21'h1B170, 21'h1B2FF)) begin
      off  = cp - 21'h1B170;
      aaaa = AaaaNushu;
      bbbb = (off[WeightW-1:0] & LowMask) | HighBit;
    end else if (in_rng(cp, 21'h18B00, 21'h18CFF)) begin
      off  = cp - 21'h18B00;
      aaaa = AaaaKhitan;
      bbbb = (off[WeightW-1:0] & LowMask) | HighBit;
    end else begin
      if (in_rng(cp, 21'h04E00, 21'h09FFF)) begin
        base = BaseCore;
      end else if (in_rng(cp, 21'h03400, 21'h04DBF) || in_rng(cp, 21'h0F900, 21'h0FAFF) ||
                   in_rng(cp, 21'h20000, 21'h2A6DF) || in_rng(cp, 21'h2A700, 21'h2B739) ||
                   in_rng(cp, 21'h2B740, 21'h2B81D) || in_rng(cp, 21'h2B820, 21'h2CEA1) ||
                   in_rng(cp, 21'h2CEB0, 21'h2EBE0) || in_rng(cp, 21'h2EBF0, 21'h2F7FF) ||
                   in_rng(cp, 21'h30000, 21'h3134A) || in_rng(cp, 21'h31350, 21'h323AF)) begin
        base = BaseExt;
      end else begin
        base = BaseOther;
      end
      off  = cp;
      aaaa = base + {10'd0, cp[CodePointW-1:15]};
      bbbb = (off[WeightW-1:0] & LowMask) | HighBit;
    end
    return {aaaa, bbbb};
  endfunction

endpackage

// ===== rtl/core/csk_ram.sv =====
// generic single-port-write ram with registered read
module csk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/collation_sort_key_builder_unit.sv =====
// collation sort key builder: ce store in ram, key emitted in up to three passes
//
//  channel | direction | payload             | handshake
//  in      | to block  | csk_pkg::in_item_t  | in_valid_i / in_ready_o
//  out     | from block| csk_pkg::out_item_t | out_valid_o / out_ready_i
//
// append and ignored items end in ST_IDLE; implicit items write again in ST_IMPL2 (one ram port)
// once a finish item is accepted, each pass reads (ST_READ) each stored ce and emits (ST_EMIT)
// its nonzero field, ST_SEP a separator after pri and sec; no nonzero tertiary skips pass ter
// no ram clearing after reset: only entries below the fill count are read
// out stalls hold the finish walk; input is taken only while no item is in progress
module collation_sort_key_builder_unit #(
  parameter int unsigned StoreDepth = csk_pkg::StoreDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csk_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csk_pkg::out_item_t  out_data_o
);

  import csk_pkg::*;

  localparam int unsigned CntW = $clog2(StoreDepth + 1);
  localparam int unsigned IdxW = $clog2(StoreDepth);

  state_e             state_q, state_d;
  pass_e              pass_q, pass_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    last_t_q, last_t_d;
  logic               has_t_q, has_t_d;
  logic               ovf_q, ovf_d;
  logic [WeightW-1:0] bbbb_q, bbbb_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               we;
  logic [IdxW-1:0]    waddr;
  ce_t                wdata;
  logic               re;
  ce_t                rdata;
  logic [CeW-1:0]     rdata_raw;

  logic               in_acc;
  logic               slot_free;
  logic [WeightW-1:0] field;
  logic [2*WeightW-1:0] imp;
  logic [CntW:0]      count_plus2;
  logic               pass_end;

  csk_ram #(
    .Width (CeW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata_raw)
  );

  assign rdata = ce_t'(rdata_raw);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign imp         = implicit_weights(in_data_i.code_point);
  assign count_plus2 = {1'b0, count_q} + (CntW+1)'(2);
  assign pass_end    = ({1'b0, idx_q} + (IdxW+1)'(1)) >= (IdxW+1)'(count_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    unique case (pass_q)
      PASS_PRI: field = rdata.p;
      PASS_SEC: field = rdata.s;
      default:  field = rdata.t;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    count_d     = count_q;
    idx_d       = idx_q;
    last_t_d    = last_t_q;
    has_t_d     = has_t_q;
    ovf_d       = ovf_q;
    bbbb_d      = bbbb_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = count_q[IdxW-1:0];
    wdata       = '0;
    re          = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.command)
            CMD_APPEND: begin
              if (count_q < CntW'(StoreDepth)) begin
                we       = 1'b1;
                wdata    = '{p: in_data_i.primary_weight, s: in_data_i.secondary_weight,
                             t: in_data_i.tertiary_weight};
                count_d  = count_q + CntW'(1);
                if (in_data_i.tertiary_weight != '0) begin
                  has_t_d  = 1'b1;
                  last_t_d = count_q[IdxW-1:0];
                end
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_IMPLICIT: begin
              if (count_plus2 <= (CntW+1)'(StoreDepth)) begin
                we       = 1'b1;
                wdata    = '{p: imp[2*WeightW-1:WeightW], s: SecImplicit, t: TerImplicit};
                bbbb_d   = imp[WeightW-1:0];
                has_t_d  = 1'b1;
                last_t_d = count_q[IdxW-1:0];
                count_d  = count_q + CntW'(1);
                state_d  = ST_IMPL2;
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_FINISH: begin
              pass_d  = PASS_PRI;
              idx_d   = '0;
              state_d = (count_q == '0) ? ST_SEP : ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_IMPL2: begin
        we      = 1'b1;
        wdata   = '{p: bbbb_q, s: '0, t: '0};
        count_d = count_q + CntW'(1);
        state_d = ST_IDLE;
      end
      ST_READ: begin
        re      = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (field == '0 || slot_free) begin
          if (field != '0) begin
            out_valid_d = 1'b1;
            out_d       = '{key_word: field,
                            last_word: (pass_q == PASS_TER) && (idx_q == last_t_q),
                            dropped: ovf_q};
          end
          idx_d = idx_q + IdxW'(1);
          if (!pass_end) begin
            state_d = ST_READ;
          end else if (pass_q == PASS_TER) begin
            count_d = '0;
            ovf_d   = 1'b0;
            has_t_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SEP;
          end
        end
      end
      ST_SEP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{key_word: '0,
                          last_word: (pass_q == PASS_SEC) && !has_t_q,
                          dropped: ovf_q};
          idx_d       = '0;
          if (pass_q == PASS_SEC && !has_t_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            pass_d  = (pass_q == PASS_PRI) ? PASS_SEC : PASS_TER;
            state_d = (count_q == '0) ? ST_SEP : ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_PRI;
      count_q     <= '0;
      idx_q       <= '0;
      last_t_q    <= '0;
      has_t_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      last_t_q    <= last_t_d;
      has_t_q     <= has_t_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bbbb_q <= bbbb_d;
    out_q  <= out_d;
  end

endmodule

// ===== tb/csk_key_checker.sv =====
// checker for the collation sort key builder: predicts the key words and compares each out beat
module csk_key_checker
  import csk_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_words_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth     = StoreDepthDef;
  localparam int PrintCap  = 40;

  // {first, last} of the cjk extension and compatibility blocks
  localparam logic [9:0][41:0] ExtBlocks = {
    {21'h03400, 21'h04DBF}, {21'h0F900, 21'h0FAFF}, {21'h20000, 21'h2A6DF},
    {21'h2A700, 21'h2B739}, {21'h2B740, 21'h2B81D}, {21'h2B820, 21'h2CEA1},
    {21'h2CEB0, 21'h2EBE0}, {21'h2EBF0, 21'h2F7FF}, {21'h30000, 21'h3134A},
    {21'h31350, 21'h323AF}
  };

  ce_t       store [Depth];
  int        fill;
  logic      overflow;
  out_item_t key_words_due [$];

  function automatic logic cp_between(input logic [CodePointW-1:0] cp, lo, hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  // {leading weight, trailing weight} of an unmapped code point
  function automatic logic [2*WeightW-1:0] implicit_pair(input logic [CodePointW-1:0] cp);
    logic [WeightW-1:0]    lead;
    logic [WeightW-1:0]    base;
    logic [CodePointW-1:0] rel;
    base = BaseOther;
    for (int i = 0; i < 10; i++) begin
      if (cp_between(cp, ExtBlocks[i][41:21], ExtBlocks[i][20:0])) begin
        base = BaseExt;
      end
    end
    if (cp_between(cp, 21'h04E00, 21'h09FFF)) begin
      base = BaseCore;
    end
    lead = base + WeightW'(cp[CodePointW-1:15]);
    rel  = cp;
    if (cp_between(cp, 21'h17000, 21'h18AFF) || cp_between(cp, 21'h18D00, 21'h18D7F)) begin
      lead = AaaaTangut;
      rel  = cp - 21'h17000;
    end else if (cp_between(cp, 21'h1B170, 21'h1B2FF)) begin
      lead = AaaaNushu;
      rel  = cp - 21'h1B170;
    end else if (cp_between(cp, 21'h18B00, 21'h18CFF)) begin
      lead = AaaaKhitan;
      rel  = cp - 21'h18B00;
    end
    return {lead, HighBit | (WeightW'(rel) & LowMask)};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < PrintCap) begin
      $display("key mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    end
    fail_count_o++;
  endtask

  task automatic predict_key(input in_item_t beat);
    logic [WeightW-1:0]   words [$];
    logic [2*WeightW-1:0] pair;
    out_item_t            w;
    case (beat.command)
      CMD_APPEND: begin
        if (fill < Depth) begin
          store[fill] = '{beat.primary_weight, beat.secondary_weight, beat.tertiary_weight};
          fill++;
        end else begin
          overflow = 1'b1;
        end
      end
      CMD_IMPLICIT: begin
        if (fill + 2 <= Depth) begin
          pair          = implicit_pair(beat.code_point);
          store[fill]   = '{pair[2*WeightW-1:WeightW], SecImplicit, TerImplicit};
          store[fill+1] = '{pair[WeightW-1:0], 16'h0000, 16'h0000};
          fill += 2;
        end else begin
          overflow = 1'b1;
        end
      end
      CMD_FINISH: begin
        for (int i = 0; i < fill; i++) begin
          if (store[i].p != 0) words.push_back(store[i].p);
        end
        words.push_back(16'h0000);
        for (int i = 0; i < fill; i++) begin
          if (store[i].s != 0) words.push_back(store[i].s);
        end
        words.push_back(16'h0000);
        for (int i = 0; i < fill; i++) begin
          if (store[i].t != 0) words.push_back(store[i].t);
        end
        foreach (words[i]) begin
          w.key_word  = words[i];
          w.last_word = (i == words.size() - 1);
          w.dropped   = overflow;
          key_words_due.push_back(w);
        end
        fill     = 0;
        overflow = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t due;
    if (key_words_due.size() == 0) begin
      report_mismatch("unexpected key word", got.key_word, 0);
      return;
    end
    due = key_words_due.pop_front();
    if (got.key_word != due.key_word) report_mismatch("key_word", got.key_word, due.key_word);
    if (got.last_word != due.last_word) begin
      report_mismatch("last_word", got.last_word, due.last_word);
    end
    if (got.dropped != due.dropped) report_mismatch("dropped", got.dropped, due.dropped);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill     = 0;
      overflow = 1'b0;
      key_words_due.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_key(in_data_i);
      if (out_valid_i && out_ready_i) check_word(out_data_i);
    end
    pending_words_o = key_words_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the collation sort key builder testbench: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csk_pkg::*;

  localparam int         RandomItems = 470;
  localparam int         StallLimit  = 4000;
  localparam int         DrainCycles = 120;
  localparam logic [1:0] CmdReserved = 2'd3;

  // eight implicit beats fill the store exactly
  localparam logic [7:0][CodePointW-1:0] FullStoreCps = {
    21'h17000, 21'h18D7F, 21'h1B170, 21'h18CFF, 21'h04E00, 21'h323AF, 21'h1FFFFF, 21'h00000
  };
  // seven implicit beats leave one free slot after an append
  localparam logic [6:0][CodePointW-1:0] NearFullCps = {
    21'h18AFF, 21'h1B2FF, 21'h18B00, 21'h09FFF, 21'h03400, 21'h0F900, 21'h10FFFF
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending_words;
  int        send_idle_pct = 16;
  int        recv_idle_pct = 81;

  collation_sort_key_builder_unit #(
    .StoreDepth(StoreDepthDef)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  csk_key_checker u_key_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .pending_words_o(pending_words)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic in_item_t make_beat(input logic [1:0] cmd, input logic [WeightW-1:0] p,
                                         s, t, input logic [CodePointW-1:0] cp);
    in_item_t beat;
    beat.command          = cmd_e'(cmd);
    beat.primary_weight   = p;
    beat.secondary_weight = s;
    beat.tertiary_weight  = t;
    beat.code_point       = cp;
    return beat;
  endfunction

  function automatic logic [WeightW-1:0] random_weight();
    if ($urandom_range(3) == 0) return '0;
    return WeightW'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [CodePointW-1:0] random_code_point();
    case ($urandom_range(7))
      0:       return CodePointW'($urandom_range(21'h18AFF, 21'h17000));
      1:       return CodePointW'($urandom_range(21'h18D7F, 21'h18CF0));
      2:       return CodePointW'($urandom_range(21'h1B2FF, 21'h1B170));
      3:       return CodePointW'($urandom_range(21'h18CFF, 21'h18B00));
      4:       return CodePointW'($urandom_range(21'h0A00F, 21'h04DF0));
      5:       return CodePointW'($urandom_range(21'h323AF, 21'h20000));
      6:       return CodePointW'($urandom_range(21'h0FFFF));
      default: return CodePointW'($urandom());
    endcase
  endfunction

  // valid stays high after a beat unless the next one starts with an idle cycle
  task automatic send_beat(input in_item_t beat);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  initial begin : stimulus
    int random_items;
    int run_len;
    int pick;
    random_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty key, then a key with no tertiaries
    send_beat(make_beat(CMD_FINISH, 16'h0000, 16'hFFFF, 16'h0000, 21'h1FFFFF));
    send_beat(make_beat(CMD_APPEND, 16'hFFFF, 16'hFFFF, 16'h0000, 21'h00000));
    send_beat(make_beat(CMD_APPEND, 16'h0000, 16'h0000, 16'h0000, 21'h1FFFFF));
    send_beat(make_beat(CMD_FINISH, 16'hFFFF, 16'h0000, 16'hFFFF, 21'h00000));
    // full store, append dropped, reserved command ignored
    for (int i = 7; i >= 0; i--) begin
      send_beat(make_beat(CMD_IMPLICIT, 16'hFFFF, 16'h0000, 16'hFFFF, FullStoreCps[i]));
    end
    send_beat(make_beat(CMD_APPEND, 16'h1234, 16'h5678, 16'h9ABC, 21'h12345));
    send_beat(make_beat(CmdReserved, 16'hFFFF, 16'hFFFF, 16'hFFFF, 21'h1FFFFF));
    send_beat(make_beat(CMD_FINISH, 16'h0000, 16'h0000, 16'h0000, 21'h00000));
    // one free slot left, implicit dropped
    for (int i = 6; i >= 0; i--) begin
      send_beat(make_beat(CMD_IMPLICIT, 16'h0000, 16'hFFFF, 16'h0000, NearFullCps[i]));
    end
    send_beat(make_beat(CMD_APPEND, 16'hFFFF, 16'h0000, 16'hFFFF, 21'h00000));
    send_beat(make_beat(CMD_IMPLICIT, 16'h0000, 16'h0000, 16'h0000, 21'h2EBF0));
    send_beat(make_beat(CMD_FINISH, 16'h0000, 16'h0000, 16'h0000, 21'h00000));

    while (random_items < RandomItems) begin
      if (random_items >= 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_items >= RandomItems / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 16;
      end
      run_len = ($urandom_range(3) == 0) ? $urandom_range(20, 12) : $urandom_range(10);
      repeat (run_len) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_beat(make_beat(CmdReserved, random_weight(), random_weight(), random_weight(),
                              random_code_point()));
        end else begin
          send_beat(make_beat((pick < 52) ? CMD_APPEND : CMD_IMPLICIT, random_weight(),
                              random_weight(), random_weight(), random_code_point()));
          random_items++;
        end
      end
      // now and then runs merge so the store overflows
      if ($urandom_range(15) != 0) begin
        send_beat(make_beat(CMD_FINISH, random_weight(), random_weight(), random_weight(),
                            random_code_point()));
        random_items++;
      end
    end
    send_beat(make_beat(CMD_FINISH, random_weight(), random_weight(), random_weight(),
                        random_code_point()));
    in_valid <= 1'b0;

    do @(negedge clk); while (pending_words != 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
